// ----- rtl/keyed_stream_descrambler_macros.svh -----
// Assertion helpers for the descrambler top level.
// Each macro expects clk and rst in scope.
`ifndef KEYED_STREAM_DESCRAMBLER_MACROS_SVH
`define KEYED_STREAM_DESCRAMBLER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define KSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define KSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ksd_pkg.sv -----
`default_nettype none

package ksd_pkg;

  // Fixed constants of the scrambling scheme
  localparam logic [31:0] SEED_MASK   = 32'h5555_5555;
  localparam logic [31:0] TABLE_MULT  = 32'd39916801;
  localparam int          TABLE_DEPTH = 256;
  localparam int          ADDR_W      = 8;

  // Request function codes
  localparam logic [2:0] FUNC_SEED  = 3'd0;
  localparam logic [2:0] FUNC_WORD  = 3'd1;
  localparam logic [2:0] FUNC_HALF  = 3'd2;
  localparam logic [2:0] FUNC_BYTE  = 3'd3;
  localparam logic [2:0] FUNC_NOKEY = 3'd4;

  // Microprogram addresses
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_SEED = 4'd1;
  localparam step_t STEP_FILL = 4'd2;
  localparam step_t STEP_PASS = 4'd3;
  localparam step_t STEP_R0   = 4'd4;
  localparam step_t STEP_R1   = 4'd5;
  localparam step_t STEP_R2   = 4'd6;
  localparam step_t STEP_R3   = 4'd7;
  localparam step_t STEP_R4   = 4'd8;

  // Sequencing operation of one control word
  typedef enum logic [2:0] {
    OP_WAIT     = 3'd0,
    OP_NEXT     = 3'd1,
    OP_END      = 3'd2,
    OP_END_BYTE = 3'd3,
    OP_END_HALF = 3'd4,
    OP_LOOP     = 3'd5
  } seq_op_t;

  // Datapath controls driven by the sequencer
  typedef struct packed {
    logic       key_seed;
    logic       fill;
    logic       rd;
    logic       fold;
    logic       out_load;
    logic [1:0] byte_sel;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic fill_last;
    logic is_byte;
    logic is_half;
    logic out_free;
  } stat_t;

  typedef struct packed {
    seq_op_t op;
    step_t   target;
    ctrl_t   ctrl;
  } uword_t;

  // Entry point of the program for a request function
  function automatic step_t entry(input logic [2:0] f);
    step_t s;
    case (f) inside
      FUNC_SEED:                      s = STEP_SEED;
      FUNC_WORD, FUNC_HALF, FUNC_BYTE: s = STEP_R0;
      default:                        s = STEP_PASS;
    endcase
    return s;
  endfunction

  // Microcode ROM
  function automatic uword_t ucode(input step_t s);
    uword_t u;
    u = '{op: OP_END, target: STEP_IDLE, ctrl: '0};
    unique case (s)
      STEP_IDLE: u.op = OP_WAIT;
      STEP_SEED: begin
        u.op = OP_NEXT;
        u.ctrl.key_seed = 1'b1;
        u.ctrl.out_load = 1'b1;
      end
      STEP_FILL: begin
        u.op = OP_LOOP;
        u.target = STEP_FILL;
        u.ctrl.fill = 1'b1;
      end
      STEP_PASS: begin
        u.op = OP_END;
        u.ctrl.out_load = 1'b1;
      end
      STEP_R0: begin
        u.op = OP_NEXT;
        u.ctrl.out_load = 1'b1;
        u.ctrl.rd = 1'b1;
        u.ctrl.byte_sel = 2'd0;
      end
      STEP_R1: begin
        u.op = OP_END_BYTE;
        u.ctrl.fold = 1'b1;
        u.ctrl.rd = 1'b1;
        u.ctrl.byte_sel = 2'd1;
      end
      STEP_R2: begin
        u.op = OP_END_HALF;
        u.ctrl.fold = 1'b1;
        u.ctrl.rd = 1'b1;
        u.ctrl.byte_sel = 2'd2;
      end
      STEP_R3: begin
        u.op = OP_NEXT;
        u.ctrl.fold = 1'b1;
        u.ctrl.rd = 1'b1;
        u.ctrl.byte_sel = 2'd3;
      end
      STEP_R4: begin
        u.op = OP_END;
        u.ctrl.fold = 1'b1;
      end
      default: u.op = OP_END;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ksd_ram.sv -----
`default_nettype none

module ksd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ksd_seq.sv -----
`default_nettype none

module ksd_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_acc,
  input  logic [2:0]     func,
  input  ksd_pkg::stat_t stat,
  output ksd_pkg::ctrl_t ctrl,
  output logic           idle
);

  import ksd_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t uw;

  assign uw   = ucode(step);
  assign ctrl = uw.ctrl;
  assign idle = (step == STEP_IDLE);

  // Pick the next step from the control word
  always_comb begin
    step_next = step;
    unique case (uw.op)
      OP_WAIT:     if (in_acc) step_next = entry(func);
      OP_NEXT:     step_next = step + 4'd1;
      OP_END:      step_next = STEP_IDLE;
      OP_END_BYTE: step_next = stat.is_byte ? STEP_IDLE : step + 4'd1;
      OP_END_HALF: step_next = stat.is_half ? STEP_IDLE : step + 4'd1;
      OP_LOOP:     step_next = stat.fill_last ? STEP_IDLE : uw.target;
      default:     step_next = STEP_IDLE;
    endcase
    // hold while the result register is still occupied
    if (uw.ctrl.out_load && !stat.out_free) begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ksd_dp.sv -----
`default_nettype none

module ksd_dp (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_acc,
  input  logic [2:0]     func,
  input  logic [31:0]    raw_data,
  input  ksd_pkg::ctrl_t ctrl,
  output ksd_pkg::stat_t stat,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [31:0]    value
);

  import ksd_pkg::*;

  logic [2:0]        func_q;
  logic [31:0]       raw_q;
  logic [31:0]       key;
  logic [31:0]       work;
  logic [ADDR_W-1:0] cnt;
  logic [31:0]       rot;
  logic [31:0]       next_word;
  logic [31:0]       masked;
  logic [ADDR_W-1:0] raddr;
  logic [31:0]       rdata;
  logic              out_commit;

  // Table word generator: rotate right by one, then scale
  assign rot       = {work[0], work[31:1]};
  assign next_word = rot * TABLE_MULT;

  assign raddr = raw_q[{ctrl.byte_sel, 3'b000} +: ADDR_W];

  ksd_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ctrl.fill),
    .waddr (cnt),
    .wdata (next_word),
    .re    (ctrl.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Result value masked to the access width
  always_comb begin
    case (func_q) inside
      FUNC_WORD, FUNC_NOKEY: masked = raw_q ^ key;
      FUNC_HALF:             masked = {16'h0000, raw_q[15:0] ^ key[15:0]};
      FUNC_BYTE:             masked = {24'h000000, raw_q[7:0] ^ key[7:0]};
      default:               masked = 32'h0000_0000;
    endcase
  end

  assign stat.fill_last = (cnt == {ADDR_W{1'b1}});
  assign stat.is_byte   = (func_q == FUNC_BYTE);
  assign stat.is_half   = (func_q == FUNC_HALF);
  assign stat.out_free  = !out_valid || !out_stall;

  assign out_commit = ctrl.out_load && stat.out_free;

  // Latch the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_q <= func;
      raw_q  <= raw_data;
    end
  end

  // Seed and fill state
  always_ff @(posedge clk) begin
    if (ctrl.key_seed) begin
      work <= raw_q ^ SEED_MASK;
      cnt  <= '0;
    end else if (ctrl.fill) begin
      work <= next_word;
      cnt  <= cnt + 1'b1;
    end
  end

  // Running key: seed or fold in one table word
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (ctrl.key_seed) begin
      key <= raw_q ^ SEED_MASK;
    end else if (ctrl.fold) begin
      key <= key ^ rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_commit) begin
      value <= masked;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/keyed_stream_descrambler.sv -----
// Channel   Handshake              Payload
// -------   --------------------   ---------------------------
// in        in_valid / in_stall    func[2:0], raw_data[31:0]
// out       out_valid / out_stall  value[31:0]
//
// One request at a time, from accept until the program is back in its idle step;
// a seed load makes 256 table writes through one multiplier and one RAM
// write port. Key updates take one registered table read per byte from
// the single read port of the table RAM.
// Reset is synchronous on rst: it clears the step counter, key and result valid.
// A stalled result holds the program at its result step until it is taken.
`default_nettype none
`include "keyed_stream_descrambler_macros.svh"

module keyed_stream_descrambler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] raw_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value
);

  import ksd_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  idle;
  logic  in_acc;

  assign in_stall = !idle;
  assign in_acc   = in_valid && idle;

  ksd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .in_acc (in_acc),
    .func   (func),
    .stat   (stat),
    .ctrl   (ctrl),
    .idle   (idle)
  );

  ksd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_acc    (in_acc),
    .func      (func),
    .raw_data  (raw_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .value     (value)
  );

  // Check program flow against the handshakes
  `KSD_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "not busy after accepted request")
  `KSD_ASSERT_NEXT(a_fill_ends_idle, ctrl.fill && stat.fill_last, !in_stall, "fill did not end")
  `KSD_ASSERT_NOW(a_result_from_load, $rose(out_valid), $past(ctrl.out_load), "stray result")

endmodule

`default_nettype wire
